[rtl/core/rc5_pkg.sv]
// Shared types, widths and codes of the RC-5 infrared frame decoder.
package rc5_pkg;

    localparam int FRAME_BITS_DEF   = 13;
    localparam int COMMAND_BITS_DEF = 6;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int TICK_W      = 16;
    localparam int HOLD_W      = 18;
    localparam int ADDR_W      = 5;
    localparam int CMD_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int KEY_W       = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;
    localparam int IN_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TMO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ADR = 3'd5;

    localparam logic [TICK_W-1:0] START_MIN_RST = 16'd400;
    localparam logic [TICK_W-1:0] START_MAX_RST = 16'd800;
    localparam logic [TICK_W-1:0] EDGE_TMO_RST  = 16'd800;
    localparam logic [TICK_W-1:0] SKIP_RST      = 16'd562;
    localparam logic [HOLD_W-1:0] HOLDOFF_RST   = 18'd156250;
    localparam logic [ADDR_W-1:0] MATCH_ADR_RST = 5'd0;

    localparam logic [STATUS_W-1:0] ST_FRAME_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_START_BAD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EDGE_TMO  = 2'd2;

    localparam logic [KEY_W-1:0] KEY_NONE     = 2'd0;
    localparam logic [KEY_W-1:0] KEY_VOL_UP   = 2'd1;
    localparam logic [KEY_W-1:0] KEY_VOL_DOWN = 2'd2;
    localparam logic [KEY_W-1:0] KEY_MUTE     = 2'd3;

    localparam int CMD_VOL_UP   = 16;
    localparam int CMD_VOL_DOWN = 17;
    localparam int CMD_MUTE     = 13;

    typedef struct packed {
        logic [TICK_W-1:0] start_min;
        logic [TICK_W-1:0] start_max;
        logic [TICK_W-1:0] edge_tmo;
        logic [TICK_W-1:0] skip;
        logic [HOLD_W-1:0] holdoff;
        logic [ADDR_W-1:0] match_adr;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   address;
        logic [CMD_W-1:0]    command;
        logic [KEY_W-1:0]    key;
    } t_result;

endpackage

[rtl/core/rc5_regs.sv]
// Configuration register bank of the RC-5 decoder.
module rc5_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [rc5_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rc5_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    output rc5_pkg::t_cfg                   o_cfg
);
    import rc5_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_min <= START_MIN_RST;
            r_cfg.start_max <= START_MAX_RST;
            r_cfg.edge_tmo  <= EDGE_TMO_RST;
            r_cfg.skip      <= SKIP_RST;
            r_cfg.holdoff   <= HOLDOFF_RST;
            r_cfg.match_adr <= MATCH_ADR_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_START_MIN: r_cfg.start_min <= i_cfg_wr_data[TICK_W-1:0];
                CFG_START_MAX: r_cfg.start_max <= i_cfg_wr_data[TICK_W-1:0];
                CFG_EDGE_TMO:  r_cfg.edge_tmo  <= i_cfg_wr_data[TICK_W-1:0];
                CFG_SKIP:      r_cfg.skip      <= i_cfg_wr_data[TICK_W-1:0];
                CFG_HOLDOFF:   r_cfg.holdoff   <= i_cfg_wr_data[HOLD_W-1:0];
                CFG_MATCH_ADR: r_cfg.match_adr <= i_cfg_wr_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/rc5_fsm.sv]
// Per-tick frame state machine: start pulse check, bit sampling and result decode.
module rc5_fsm #(
    parameter int FRAME_BITS   = rc5_pkg::FRAME_BITS_DEF,
    parameter int COMMAND_BITS = rc5_pkg::COMMAND_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick,
    input  logic             i_level,
    input  rc5_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output rc5_pkg::t_result o_res
);
    import rc5_pkg::*;

    localparam int BITS_W = $clog2(FRAME_BITS + 1);
    localparam int CNT_W  = HOLD_W;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_EDGE  = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_HOLD  = 3'd4;

    localparam logic [FRAME_BITS-1:0] BODY_MASK = {2'b00, {(FRAME_BITS-2){1'b1}}};

    logic [2:0]            r_phase, n_phase;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [BITS_W-1:0]     r_bits, n_bits;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic                  r_latched, n_latched;

    logic [CNT_W:0]          w_inc;
    logic [FRAME_BITS-1:0]   w_body;
    logic [FRAME_BITS-1:0]   w_body_shr;
    logic [COMMAND_BITS-1:0] w_cmd_full;
    logic [KEY_W-1:0]        w_key;
    logic                    w_valid;
    t_result                 w_res;

    assign w_inc      = {1'b0, r_cnt} + (CNT_W+1)'(1);
    assign w_body     = r_shift & BODY_MASK;
    assign w_body_shr = w_body >> COMMAND_BITS;
    assign w_cmd_full = w_body[COMMAND_BITS-1:0];

    always_comb begin
        w_key = KEY_NONE;
        if (w_body_shr[ADDR_W-1:0] == i_cfg.match_adr) begin
            if (w_cmd_full == COMMAND_BITS'(CMD_VOL_UP)) begin
                w_key = KEY_VOL_UP;
            end else if (w_cmd_full == COMMAND_BITS'(CMD_VOL_DOWN)) begin
                w_key = KEY_VOL_DOWN;
            end else if (w_cmd_full == COMMAND_BITS'(CMD_MUTE)) begin
                w_key = KEY_MUTE;
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_latched = r_latched;
        w_valid   = 1'b0;
        w_res     = '0;
        if (i_tick) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_level) begin
                        n_phase = PH_START;
                        n_cnt   = CNT_W'(1);
                        n_bits  = '0;
                        n_shift = '0;
                        if (i_cfg.start_max == '0) begin
                            n_phase      = PH_IDLE;
                            n_cnt        = '0;
                            w_valid      = 1'b1;
                            w_res.status = ST_START_BAD;
                        end
                    end
                end
                PH_START: begin
                    if (i_level) begin
                        n_cnt = w_inc[CNT_W-1:0];
                        if (w_inc > (CNT_W+1)'(i_cfg.start_max)) begin
                            n_phase      = PH_IDLE;
                            n_cnt        = '0;
                            w_valid      = 1'b1;
                            w_res.status = ST_START_BAD;
                        end
                    end else if (r_cnt < CNT_W'(i_cfg.start_min)) begin
                        n_phase      = PH_IDLE;
                        n_cnt        = '0;
                        w_valid      = 1'b1;
                        w_res.status = ST_START_BAD;
                    end else begin
                        n_latched = 1'b0;
                        n_cnt     = '0;
                        n_phase   = PH_EDGE;
                    end
                end
                PH_EDGE: begin
                    if (i_level == r_latched) begin
                        n_cnt = w_inc[CNT_W-1:0];
                        if (w_inc > (CNT_W+1)'(i_cfg.edge_tmo)) begin
                            n_phase      = PH_IDLE;
                            n_cnt        = '0;
                            w_valid      = 1'b1;
                            w_res.status = ST_EDGE_TMO;
                        end
                    end else begin
                        n_shift = {r_shift[FRAME_BITS-2:0], ~r_latched};
                        n_bits  = r_bits + BITS_W'(1);
                        n_cnt   = '0;
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (r_cnt < CNT_W'(i_cfg.skip)) begin
                        n_cnt = w_inc[CNT_W-1:0];
                    end else if (r_bits >= BITS_W'(FRAME_BITS)) begin
                        n_cnt         = '0;
                        n_phase       = (i_cfg.holdoff == '0) ? PH_IDLE : PH_HOLD;
                        w_valid       = 1'b1;
                        w_res.status  = ST_FRAME_OK;
                        w_res.address = w_body_shr[ADDR_W-1:0];
                        w_res.command = w_body[CMD_W-1:0];
                        w_res.key     = w_key;
                    end else begin
                        n_latched = i_level;
                        n_cnt     = '0;
                        n_phase   = PH_EDGE;
                    end
                end
                PH_HOLD: begin
                    n_cnt = w_inc[CNT_W-1:0];
                    if (w_inc >= (CNT_W+1)'(i_cfg.holdoff)) begin
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_bits    <= '0;
            r_shift   <= '0;
            r_latched <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_bits    <= n_bits;
            r_shift   <= n_shift;
            r_latched <= n_latched;
        end
    end

    assign o_res_valid = w_valid;
    assign o_res       = w_res;

    a_res_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid |-> i_tick)
        else $error("Result produced without an accepted word.");

    a_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid |=> (r_phase == PH_IDLE || r_phase == PH_HOLD))
        else $error("Decoder not idle or holding after a result.");

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EDGE) |-> (r_bits < BITS_W'(FRAME_BITS)))
        else $error("Bit count overran the frame length.");

    a_fail_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid && w_res.status != ST_FRAME_OK) |=> (r_cnt == '0))
        else $error("Tick count not cleared after a failure.");

endmodule

[rtl/core/rc5_out.sv]
// Result register that decouples the decoder from the output stream.
module rc5_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  rc5_pkg::t_result i_res,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output rc5_pkg::t_result o_res
);
    import rc5_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !i_res_valid)
        else $error("Pending result would be overwritten.");

endmodule

[rtl/core/rc5_ir_frame_decoder.sv]
// Top level of the RC-5 infrared frame decoder.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata[0] ir_level, one word per timer tick
//  m_axis    out        tuser status, tdata address, command and key action
//  cfg       in         write enable, register index, write data
//
// One input word is taken every cycle while tready is high, and its result is registered in the output register.
// The state machine and the result register are the whole datapath.
// Input tready drops only while a result waits in the output register and the
// downstream side stalls.
// Reset loads the register defaults and returns the decoder to idle.
module rc5_ir_frame_decoder #(
    parameter int FRAME_BITS   = rc5_pkg::FRAME_BITS_DEF,
    parameter int COMMAND_BITS = rc5_pkg::COMMAND_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Fields: [0] ir_level, [7:1] zero.
    input  logic [rc5_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // Fields: [4:0] frame_address, [10:5] frame_command, [12:11] key_action, [15:13] zero.
    output logic [rc5_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // Fields: [1:0] frame_status.
    output logic [rc5_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    input  logic                               i_cfg_wr_en,
    input  logic [rc5_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rc5_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data
);
    import rc5_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    t_result w_out_res;
    logic    w_res_valid;
    logic    w_space;
    logic    w_tick;

    assign o_s_axis_tready = w_space;
    assign w_tick          = i_s_axis_tvalid && w_space;

    rc5_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (w_cfg)
    );

    rc5_fsm #(
        .FRAME_BITS   (FRAME_BITS),
        .COMMAND_BITS (COMMAND_BITS)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_tick),
        .i_level     (i_s_axis_tdata[0]),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    rc5_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_space     (w_space),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (w_out_res)
    );

    assign o_m_axis_tdata = {3'b000, w_out_res.key, w_out_res.command, w_out_res.address};
    assign o_m_axis_tuser = w_out_res.status;

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the RC-5 frame decoder: directed and random tick streams vs. a decoder model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rc5_pkg::*;

    localparam int NBITS       = FRAME_BITS_DEF;
    localparam int NO_STOP     = NBITS;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_MATCH_ADR + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum logic [2:0] {P_IDLE, P_START, P_EDGE, P_SKIP, P_HOLD} t_dec_phase;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wr_data = '0;

    logic       tick_q[$];
    t_result    frame_expect_q[$];
    t_cfg       dec_cfg;
    t_dec_phase dec_phase = P_IDLE;
    logic [17:0]      dec_count = '0;
    logic [3:0]       dec_bits = '0;
    logic [NBITS-1:0] dec_shift = '0;
    logic             dec_latched = 1'b0;

    bit failed = 1'b0;
    bit no_gaps = 1'b0;
    int ticks_taken = 0;
    int results_seen = 0;
    int cycle_cnt = 0;

    rc5_ir_frame_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    task automatic decode_tick(input logic lvl);
        t_result          res;
        bit               hit;
        logic [NBITS-3:0] body;
        res = '0;
        hit = 1'b0;
        case (dec_phase)
            P_IDLE: begin
                if (lvl) begin
                    dec_phase = P_START;
                    dec_count = 18'd1;
                    dec_bits = '0;
                    dec_shift = '0;
                    if (dec_count > dec_cfg.start_max) begin
                        res.status = ST_START_BAD;
                        hit = 1'b1;
                    end
                end
            end
            P_START: begin
                if (lvl) begin
                    dec_count++;
                    if (dec_count > dec_cfg.start_max) begin
                        res.status = ST_START_BAD;
                        hit = 1'b1;
                    end
                end else if (dec_count < dec_cfg.start_min) begin
                    res.status = ST_START_BAD;
                    hit = 1'b1;
                end else begin
                    dec_latched = lvl;
                    dec_count = '0;
                    dec_phase = P_EDGE;
                end
            end
            P_EDGE: begin
                if (lvl == dec_latched) begin
                    dec_count++;
                    if (dec_count > dec_cfg.edge_tmo) begin
                        res.status = ST_EDGE_TMO;
                        hit = 1'b1;
                    end
                end else begin
                    dec_shift = {dec_shift[NBITS-2:0], ~dec_latched};
                    dec_bits++;
                    dec_count = '0;
                    dec_phase = P_SKIP;
                end
            end
            P_SKIP: begin
                if (dec_count < dec_cfg.skip) begin
                    dec_count++;
                end else if (dec_bits >= NBITS) begin
                    body = dec_shift[NBITS-3:0];
                    res.status = ST_FRAME_OK;
                    res.command = body[CMD_W-1:0];
                    res.address = body[CMD_W +: ADDR_W];
                    res.key = KEY_NONE;
                    if (res.address == dec_cfg.match_adr) begin
                        case (int'(res.command))
                            CMD_VOL_UP: res.key = KEY_VOL_UP;
                            CMD_VOL_DOWN: res.key = KEY_VOL_DOWN;
                            CMD_MUTE: res.key = KEY_MUTE;
                            default: res.key = KEY_NONE;
                        endcase
                    end
                    hit = 1'b1;
                    dec_count = '0;
                    dec_phase = (dec_cfg.holdoff == 0) ? P_IDLE : P_HOLD;
                end else begin
                    dec_latched = lvl;
                    dec_count = '0;
                    dec_phase = P_EDGE;
                end
            end
            P_HOLD: begin
                dec_count++;
                if (dec_count >= dec_cfg.holdoff) begin
                    dec_phase = P_IDLE;
                    dec_count = '0;
                end
            end
            default: begin
                dec_phase = P_IDLE;
                dec_count = '0;
            end
        endcase
        if (hit && res.status != ST_FRAME_OK) begin
            dec_phase = P_IDLE;
            dec_count = '0;
        end
        if (hit) begin
            frame_expect_q.push_back(res);
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.status = o_m_axis_tuser[STATUS_W-1:0];
        got.address = o_m_axis_tdata[ADDR_W-1:0];
        got.command = o_m_axis_tdata[ADDR_W +: CMD_W];
        got.key = o_m_axis_tdata[ADDR_W+CMD_W +: KEY_W];
        results_seen++;
        if (frame_expect_q.size() == 0) begin
            $error("result word with no expectation: frame_status %0d", got.status);
            failed = 1'b1;
        end else begin
            want = frame_expect_q.pop_front();
            if (got.status !== want.status) begin
                $error("frame_status: expected %0d, actual %0d", want.status, got.status);
                failed = 1'b1;
            end
            if (got.address !== want.address) begin
                $error("frame_address: expected %0d, actual %0d", want.address, got.address);
                failed = 1'b1;
            end
            if (got.command !== want.command) begin
                $error("frame_command: expected %0d, actual %0d", want.command, got.command);
                failed = 1'b1;
            end
            if (got.key !== want.key) begin
                $error("key_action: expected %0d, actual %0d", want.key, got.key);
                failed = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decode_tick(i_s_axis_tdata[0]);
                ticks_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tick_q.size() != 0 && (no_gaps || $urandom_range(99) >= 38)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, tick_q.pop_front()};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_result();
            end
            i_m_axis_tready <= no_gaps || $urandom_range(99) >= 38;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        logic [CFG_DATA_W-1:0] wd;
        wd = CFG_DATA_W'($urandom);
        case (idx)
            CFG_START_MIN: begin
                wd[TICK_W-1:0] = val[TICK_W-1:0];
                dec_cfg.start_min = val[TICK_W-1:0];
            end
            CFG_START_MAX: begin
                wd[TICK_W-1:0] = val[TICK_W-1:0];
                dec_cfg.start_max = val[TICK_W-1:0];
            end
            CFG_EDGE_TMO: begin
                wd[TICK_W-1:0] = val[TICK_W-1:0];
                dec_cfg.edge_tmo = val[TICK_W-1:0];
            end
            CFG_SKIP: begin
                wd[TICK_W-1:0] = val[TICK_W-1:0];
                dec_cfg.skip = val[TICK_W-1:0];
            end
            CFG_HOLDOFF: begin
                wd = val[HOLD_W-1:0];
                dec_cfg.holdoff = val[HOLD_W-1:0];
            end
            CFG_MATCH_ADR: begin
                wd[ADDR_W-1:0] = val[ADDR_W-1:0];
                dec_cfg.match_adr = val[ADDR_W-1:0];
            end
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wr_data <= wd;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Bits go out first to last; each bit is a latch tick, a wait at that level,
    // the mid-bit transition and the skipped ticks. A stop bit ends in a timeout.
    task automatic queue_frame(input logic [ADDR_W-1:0] adr, input logic [CMD_W-1:0] cmd,
                               input int pulse, input int stop_bit);
        logic [NBITS-1:0] word;
        logic             lvl;
        int               w;
        word = {1'b1, 1'($urandom_range(1)), adr, cmd};
        repeat (pulse) tick_q.push_back(1'b1);
        for (int k = 0; k < NBITS; k++) begin
            lvl = ~word[NBITS-1-k];
            if (k == stop_bit) begin
                repeat (dec_cfg.edge_tmo + 2) tick_q.push_back(lvl);
                return;
            end
            case ($urandom_range(3))
                0: w = 0;
                1: w = dec_cfg.edge_tmo;
                default: w = $urandom_range(dec_cfg.edge_tmo, 0);
            endcase
            repeat (w + 1) tick_q.push_back(lvl);
            tick_q.push_back(~lvl);
            repeat (dec_cfg.skip) tick_q.push_back(1'($urandom_range(1)));
        end
        tick_q.push_back(1'($urandom_range(1)));
        repeat (dec_cfg.holdoff) tick_q.push_back(1'($urandom_range(1)));
    endtask

    task automatic settle();
        do begin
            while (tick_q.size() != 0 || i_s_axis_tvalid || frame_expect_q.size() != 0)
                @(negedge i_clk);
            repeat (4) @(posedge i_clk);
            if (dec_phase != P_IDLE) begin
                repeat (16) tick_q.push_back(1'b0);
            end
        end while (tick_q.size() != 0);
    endtask

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int                lo;
        int                round;
        int                pick;
        logic [ADDR_W-1:0] adr;
        logic [CMD_W-1:0]  cmd;
        dec_cfg = '{start_min: START_MIN_RST, start_max: START_MAX_RST, edge_tmo: EDGE_TMO_RST,
                    skip: SKIP_RST, holdoff: HOLDOFF_RST, match_adr: MATCH_ADR_RST};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: a short pulse is rejected.
        repeat (5) tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        settle();

        write_reg(CFG_START_MIN, 2);
        write_reg(CFG_START_MAX, 6);
        write_reg(CFG_EDGE_TMO, 4);
        write_reg(CFG_SKIP, 2);
        write_reg(CFG_HOLDOFF, 0);
        write_reg(CFG_MATCH_ADR, 0);
        queue_frame('0, CMD_W'(CMD_VOL_UP), 2, NO_STOP);
        queue_frame('0, CMD_W'(CMD_VOL_DOWN), 6, NO_STOP);
        queue_frame(ADDR_W'(7), CMD_W'(CMD_MUTE), 4, NO_STOP);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        repeat (7) tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        queue_frame('0, CMD_W'(CMD_MUTE), 3, 0);
        settle();

        write_reg(CFG_START_MIN, 0);
        write_reg(CFG_START_MAX, 65535);
        write_reg(CFG_EDGE_TMO, 0);
        write_reg(CFG_SKIP, 0);
        write_reg(CFG_HOLDOFF, 3);
        write_reg(CFG_MATCH_ADR, 31);
        queue_frame('1, CMD_W'(CMD_VOL_UP), 1, NO_STOP);
        queue_frame('1, CMD_W'(CMD_MUTE), 8, NO_STOP);
        queue_frame('1, CMD_W'(42), 3, 6);
        repeat (24) tick_q.push_back(1'($urandom_range(1)));
        repeat (9) tick_q.push_back(1'b0);
        settle();

        // A zero maximum rejects every pulse on its first tick.
        write_reg(CFG_START_MIN, 65535);
        write_reg(CFG_START_MAX, 0);
        write_reg(CFG_EDGE_TMO, 65535);
        write_reg(CFG_SKIP, 65535);
        write_reg(CFG_HOLDOFF, 262143);
        write_reg(CFG_MATCH_ADR, 0);
        write_reg(CFG_SPARE_LO, 0);
        write_reg(CFG_SPARE_HI, 262143);
        repeat (30) tick_q.push_back(1'($urandom_range(1)));
        tick_q.push_back(1'b0);
        settle();

        round = 0;
        while (round < 2 || ticks_taken < 650) begin
            lo = $urandom_range(4);
            write_reg(CFG_START_MIN, lo);
            write_reg(CFG_START_MAX, lo + $urandom_range(5, 1));
            write_reg(CFG_EDGE_TMO, $urandom_range(5));
            write_reg(CFG_SKIP, $urandom_range(4));
            write_reg(CFG_HOLDOFF, $urandom_range(1) ? 0 : $urandom_range(6, 1));
            write_reg(CFG_MATCH_ADR, $urandom_range(31));
            if (lo == 0) begin
                lo = 1;
            end
            no_gaps = (round == 1);
            repeat (2) begin
                adr = $urandom_range(1) ? dec_cfg.match_adr : ADDR_W'($urandom);
                case ($urandom_range(4))
                    0: cmd = CMD_W'(CMD_VOL_UP);
                    1: cmd = CMD_W'(CMD_VOL_DOWN);
                    2: cmd = CMD_W'(CMD_MUTE);
                    default: cmd = CMD_W'($urandom);
                endcase
                pick = $urandom_range(99);
                if (pick < 70) begin
                    queue_frame(adr, cmd, $urandom_range(dec_cfg.start_max, lo), NO_STOP);
                end else if (pick < 80) begin
                    if (dec_cfg.start_min >= 2 && $urandom_range(1)) begin
                        repeat ($urandom_range(dec_cfg.start_min - 1, 1)) tick_q.push_back(1'b1);
                    end else begin
                        repeat (dec_cfg.start_max + 1) tick_q.push_back(1'b1);
                    end
                    tick_q.push_back(1'b0);
                end else if (pick < 90) begin
                    queue_frame(adr, cmd, lo, $urandom_range(NBITS - 1));
                end else begin
                    repeat ($urandom_range(20, 3)) tick_q.push_back(1'($urandom_range(1)));
                    repeat (dec_cfg.skip + 2 * dec_cfg.edge_tmo + dec_cfg.holdoff + 6)
                        tick_q.push_back(1'b0);
                end
                repeat ($urandom_range(3)) tick_q.push_back(1'b0);
            end
            settle();
            round++;
        end
        no_gaps = 1'b0;

        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rc5_pkg.sv
rtl/core/rc5_regs.sv
rtl/core/rc5_fsm.sv
rtl/core/rc5_out.sv
rtl/core/rc5_ir_frame_decoder.sv
tb/tb_top.sv
